### src/tlb_pkg.sv
// tlb_pkg: shared types and constants for the age-ordered translation buffer
// holds entry sizing, request/response words, cell control and fsm states
// no dependencies
package tlb_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int PAGE_BITS   = 20;
	localparam int FRAME_BITS  = 20;
	localparam int CAP_W       = 5;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [PAGE_BITS-1:0]  page_t;
	typedef logic [FRAME_BITS-1:0] frame_t;

	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_FLUSH  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic {
		CFG_REPLACE_MODE   = 1'b0,
		CFG_ENTRIES_IN_USE = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		page_t      page_number;
		frame_t     frame_number;
	} req_word_t;

	typedef struct packed {
		logic   hit;
		frame_t found_frame;
		logic   evicted;
		page_t  evicted_page;
	} rsp_word_t;

	// per-cell control from the row controller
	typedef struct packed {
		logic occupied;
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

### src/tlb_cell.sv
// tlb_cell: one slot of the age-ordered row, holds a page and its frame
// takes the neighbour's entry on a shift or the shared load bus on a load
// depends on tlb_pkg
module tlb_cell (
	input  logic              clk,
	input  tlb_pkg::cell_ctl_t ctl,
	input  tlb_pkg::page_t    cmp_page,
	input  tlb_pkg::page_t    next_page,
	input  tlb_pkg::frame_t   next_frame,
	input  tlb_pkg::page_t    load_page,
	input  tlb_pkg::frame_t   load_frame,
	output tlb_pkg::page_t    page,
	output tlb_pkg::frame_t   frame,
	output logic              match
);

	tlb_pkg::page_t  page_q;
	tlb_pkg::frame_t frame_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			page_q  <= load_page;
			frame_q <= load_frame;
		end else if (ctl.shift) begin
			page_q  <= next_page;
			frame_q <= next_frame;
		end
	end

	assign page  = page_q;
	assign frame = frame_q;
	assign match = ctl.occupied && (page_q == cmp_page);

endmodule

### src/tlb_fifo_lru_lookup.sv
// tlb_fifo_lru_lookup: fully associative translation buffer, top level
// row controller, fill count, config registers and output register
// depends on tlb_pkg and tlb_cell
//
// A word is captured first; then all MAX_ENTRIES cells compare the page
// in parallel, the first (oldest) match is picked, and the row shifts by
// one toward the oldest end as an entry is dropped, with the reinserted or
// new entry loaded at the youngest occupied slot (the first free slot when
// the row grows). The response sits in an output register, so a new
// request is taken while the previous response still waits; the execute
// step waits only when that register is full and stalled. Slot 0 is the oldest
// entry. Slot contents are not cleared by reset or flush; only the fill count is.
module tlb_fifo_lru_lookup (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  tlb_pkg::req_word_t    req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output tlb_pkg::rsp_word_t    rsp,
	input  logic                  cfg_we,
	input  tlb_pkg::cfg_idx_t     cfg_index,
	input  logic [tlb_pkg::CAP_W-1:0] cfg_data
);

	localparam int N = tlb_pkg::MAX_ENTRIES;

	tlb_pkg::state_t    state_q, state_nxt;
	tlb_pkg::req_word_t req_s1;
	tlb_pkg::rsp_word_t rsp_q;
	logic               rsp_valid_q;
	tlb_pkg::cnt_t      fill_q, fill_nxt;
	logic               replace_mode_q;
	logic [tlb_pkg::CAP_W-1:0] entries_in_use_q;

	logic               accept, exec_fire, rsp_free;

	tlb_pkg::cell_ctl_t ctl   [N];
	tlb_pkg::page_t     c_page [N];
	tlb_pkg::frame_t    c_frame[N];
	logic [N-1:0]       match;

	logic               any_match, is_lookup, is_insert, is_flush;
	logic               lookup_hit, evict, drop, load_en, grow;
	tlb_pkg::idx_t      first_idx, drop_idx;
	tlb_pkg::cnt_t      load_pos, cap;
	tlb_pkg::frame_t    hit_frame;
	tlb_pkg::page_t     load_page;
	tlb_pkg::frame_t    load_frame;
	tlb_pkg::rsp_word_t rsp_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_mode_q   <= 1'b0;
			entries_in_use_q <= tlb_pkg::CAP_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlb_pkg::CFG_REPLACE_MODE:   replace_mode_q   <= cfg_data[0];
				tlb_pkg::CFG_ENTRIES_IN_USE: entries_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective capacity, clamped to 1..MAX_ENTRIES
	always_comb begin
		if (entries_in_use_q == '0)
			cap = tlb_pkg::cnt_t'(1);
		else if (32'(entries_in_use_q) > N)
			cap = tlb_pkg::cnt_t'(N);
		else
			cap = tlb_pkg::cnt_t'(entries_in_use_q);
	end

	// fsm: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tlb_pkg::ST_IDLE: if (req_valid) state_nxt = tlb_pkg::ST_EXEC;
			tlb_pkg::ST_EXEC: if (rsp_free)  state_nxt = tlb_pkg::ST_IDLE;
			default:          state_nxt = tlb_pkg::ST_IDLE;
		endcase
	end

	// fsm: outputs
	always_comb begin
		rsp_free  = !rsp_valid_q || !rsp_stall;
		req_stall = (state_q != tlb_pkg::ST_IDLE);
		accept    = (state_q == tlb_pkg::ST_IDLE) && req_valid;
		exec_fire = (state_q == tlb_pkg::ST_EXEC) && rsp_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tlb_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
	end

	// oldest match wins
	always_comb begin
		any_match = 1'b0;
		first_idx = '0;
		hit_frame = '0;
		for (int k = 0; k < N; k++) begin
			if (match[k] && !any_match) begin
				any_match = 1'b1;
				first_idx = tlb_pkg::idx_t'(k);
				hit_frame = c_frame[k];
			end
		end
	end

	always_comb begin
		is_lookup  = (req_s1.func == tlb_pkg::FUNC_LOOKUP);
		is_insert  = (req_s1.func == tlb_pkg::FUNC_INSERT);
		is_flush   = (req_s1.func == tlb_pkg::FUNC_FLUSH);
		lookup_hit = is_lookup && any_match;
		evict      = is_insert && (fill_q != '0) && (fill_q >= cap);
		drop       = (lookup_hit && replace_mode_q) || evict;
		drop_idx   = evict ? '0 : first_idx;
		grow       = is_insert && !evict && (fill_q < tlb_pkg::cnt_t'(N));
		load_en    = drop || grow;
		load_pos   = drop ? fill_q - tlb_pkg::cnt_t'(1) : fill_q;
		load_page  = req_s1.page_number;
		load_frame = is_lookup ? hit_frame : req_s1.frame_number;

		fill_nxt = fill_q;
		if (is_flush)
			fill_nxt = '0;
		else if (grow)
			fill_nxt = fill_q + tlb_pkg::cnt_t'(1);
	end

	// per-cell control
	always_comb begin
		for (int k = 0; k < N; k++) begin
			ctl[k].occupied = (tlb_pkg::cnt_t'(k) < fill_q);
			ctl[k].load     = exec_fire && load_en && (tlb_pkg::cnt_t'(k) == load_pos);
			ctl[k].shift    = exec_fire && drop
				&& (tlb_pkg::cnt_t'(k) >= tlb_pkg::cnt_t'(drop_idx))
				&& (tlb_pkg::cnt_t'(k + 1) < fill_q);
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		tlb_pkg::page_t  nb_page;
		tlb_pkg::frame_t nb_frame;
		if (g == N - 1) begin : g_end
			// the youngest slot never shifts
			assign nb_page  = load_page;
			assign nb_frame = load_frame;
		end else begin : g_mid
			assign nb_page  = c_page[g+1];
			assign nb_frame = c_frame[g+1];
		end
		tlb_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[g]),
			.cmp_page   (req_s1.page_number),
			.next_page  (nb_page),
			.next_frame (nb_frame),
			.load_page  (load_page),
			.load_frame (load_frame),
			.page       (c_page[g]),
			.frame      (c_frame[g]),
			.match      (match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (exec_fire)
			fill_q <= fill_nxt;
	end

	always_comb begin
		rsp_nxt.hit          = lookup_hit;
		rsp_nxt.found_frame  = lookup_hit ? hit_frame : '0;
		rsp_nxt.evicted      = evict;
		rsp_nxt.evicted_page = evict ? c_page[0] : '0;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (exec_fire)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec_fire)
			rsp_q <= rsp_nxt;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### src/tlb_checker.sv
// tlb_checker: port-level checks for the translation buffer
// bound to tlb_fifo_lru_lookup, depends on tlb_pkg
module tlb_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_stall,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input tlb_pkg::rsp_word_t    rsp
);

	// one word in flight: an accepted word blocks the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("word accepted on consecutive cycles");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_hit_xor_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.evicted))
		else $error("hit and eviction in one response");

	a_miss_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.found_frame == '0)
		else $error("frame reported without a hit");

	a_no_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.evicted |-> rsp.evicted_page == '0)
		else $error("page reported without an eviction");

endmodule

bind tlb_fifo_lru_lookup tlb_checker u_tlb_checker (.*);

### tb/tb.sv
// tb: self-checking bench for tlb_fifo_lru_lookup, age-ordered translation buffer
// scripted directed words first, then random words under several register settings
// depends on tlb_pkg and the tlb_fifo_lru_lookup rtl
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG      = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_SHOWN     = 10;
	localparam int HOT           = 12;
	localparam int PHASES        = 6;
	localparam int PHASE_WORDS   = 90;

	typedef struct {
		bit                        is_cfg;
		bit                        mode;
		logic [tlb_pkg::CAP_W-1:0] cap;
		tlb_pkg::req_word_t        w;
		bit                        known;
		tlb_pkg::rsp_word_t        r;
	} script_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      req_valid;
	logic                      req_stall;
	tlb_pkg::req_word_t        req;
	logic                      rsp_valid;
	logic                      rsp_stall;
	tlb_pkg::rsp_word_t        rsp;
	logic                      cfg_we;
	tlb_pkg::cfg_idx_t         cfg_index;
	logic [tlb_pkg::CAP_W-1:0] cfg_data;

	// shadow of the buffer contents and registers
	tlb_pkg::page_t            slot_page[tlb_pkg::MAX_ENTRIES];
	tlb_pkg::frame_t           slot_frame[tlb_pkg::MAX_ENTRIES];
	int                        held = 0;
	bit                        lru_mode = 1'b0;
	logic [tlb_pkg::CAP_W-1:0] cap_reg = 5'd16;

	tlb_pkg::rsp_word_t expected_rsp[$];
	script_row_t        script[$];
	tlb_pkg::page_t     hot_pages[HOT];

	bit                        phase_mode[PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	logic [tlb_pkg::CAP_W-1:0] phase_cap[PHASES]  = '{5'd16, 5'd16, 5'd31, 5'd3, 5'd0, 5'd8};

	int                 send_idle_pct = 38;
	int                 recv_idle_pct = 46;
	int                 bad = 0;
	int                 quiet_cycles = 0;
	int                 n_words = 0, n_lookups = 0, n_hits = 0, n_inserts = 0;
	int                 n_evictions = 0, n_flushes = 0, n_checked = 0;
	bit                 rsp_go = 1'b0;
	tlb_pkg::rsp_word_t rsp_snap;

	tlb_fifo_lru_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void drop_entry(int idx);
		for (int k = idx; k + 1 < held; k++) begin
			slot_page[k]  = slot_page[k + 1];
			slot_frame[k] = slot_frame[k + 1];
		end
		held--;
	endfunction

	function automatic void push_entry(tlb_pkg::page_t p, tlb_pkg::frame_t f);
		if (held < tlb_pkg::MAX_ENTRIES) begin
			slot_page[held]  = p;
			slot_frame[held] = f;
			held++;
		end
	endfunction

	function automatic tlb_pkg::rsp_word_t translate(tlb_pkg::req_word_t w);
		tlb_pkg::rsp_word_t r;
		int                 hit_at;
		int                 limit;
		tlb_pkg::page_t     p;
		tlb_pkg::frame_t    f;
		r = '0;
		hit_at = -1;
		// zero acts as one, anything past the row acts as the full row
		limit = (cap_reg == 0) ? 1 :
			(cap_reg > tlb_pkg::MAX_ENTRIES) ? tlb_pkg::MAX_ENTRIES : int'(cap_reg);
		unique case (tlb_pkg::func_t'(w.func))
			tlb_pkg::FUNC_LOOKUP: begin
				for (int k = 0; k < held; k++)
					if (hit_at < 0 && slot_page[k] == w.page_number)
						hit_at = k;
				if (hit_at >= 0) begin
					r.hit = 1'b1;
					r.found_frame = slot_frame[hit_at];
					if (lru_mode) begin
						p = slot_page[hit_at];
						f = slot_frame[hit_at];
						drop_entry(hit_at);
						push_entry(p, f);
					end
				end
			end
			tlb_pkg::FUNC_INSERT: begin
				if (held >= limit && held > 0) begin
					r.evicted = 1'b1;
					r.evicted_page = slot_page[0];
					drop_entry(0);
				end
				push_entry(w.page_number, w.frame_number);
			end
			tlb_pkg::FUNC_FLUSH: held = 0;
			default: ;
		endcase
		return r;
	endfunction

	function automatic void row_regs(bit mode, logic [tlb_pkg::CAP_W-1:0] cap);
		script_row_t s;
		s = '{1'b1, mode, cap, '0, 1'b0, '0};
		script.push_back(s);
	endfunction

	function automatic void row_word(tlb_pkg::func_t fn, tlb_pkg::page_t p,
		tlb_pkg::frame_t f);
		script_row_t s;
		s = '{1'b0, 1'b0, '0, {fn, p, f}, 1'b0, '0};
		script.push_back(s);
	endfunction

	function automatic void row_known(tlb_pkg::func_t fn, tlb_pkg::page_t p,
		tlb_pkg::frame_t f, tlb_pkg::rsp_word_t r);
		script_row_t s;
		s = '{1'b0, 1'b0, '0, {fn, p, f}, 1'b1, r};
		script.push_back(s);
	endfunction

	task automatic send_word(tlb_pkg::req_word_t w, bit known, tlb_pkg::rsp_word_t given);
		tlb_pkg::rsp_word_t predicted;
		bit                 taken;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		taken = 1'b0;
		while (!taken) begin
			// stall is settled by the falling edge and holds until the next rise
			@(negedge clk);
			taken = !req_stall;
			if (taken) begin
				predicted = translate(w);
				expected_rsp.push_back(known ? given : predicted);
				n_words++;
				unique case (tlb_pkg::func_t'(w.func))
					tlb_pkg::FUNC_LOOKUP: begin
						n_lookups++;
						n_hits += predicted.hit;
					end
					tlb_pkg::FUNC_INSERT: begin
						n_inserts++;
						n_evictions += predicted.evicted;
					end
					tlb_pkg::FUNC_FLUSH: n_flushes++;
					default: ;
				endcase
			end
			@(posedge clk);
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(bit mode, logic [tlb_pkg::CAP_W-1:0] cap);
		cfg_we <= 1'b1;
		cfg_index <= tlb_pkg::CFG_REPLACE_MODE;
		cfg_data <= {{(tlb_pkg::CAP_W - 1){1'b0}}, mode};
		@(posedge clk);
		cfg_index <= tlb_pkg::CFG_ENTRIES_IN_USE;
		cfg_data <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		lru_mode = mode;
		cap_reg = cap;
	endtask

	task automatic check_word(tlb_pkg::rsp_word_t got);
		tlb_pkg::rsp_word_t want;
		if (expected_rsp.size() == 0) begin
			bad++;
			if (bad <= MAX_SHOWN)
				$display("unexpected response word %h", got);
		end else begin
			want = expected_rsp.pop_front();
			if (got.hit !== want.hit || got.found_frame !== want.found_frame ||
			    got.evicted !== want.evicted || got.evicted_page !== want.evicted_page) begin
				bad++;
				if (bad <= MAX_SHOWN)
					$display("word %0d: hit %b/%b frame %h/%h evicted %b/%b page %h/%h (exp/got)",
						n_checked, want.hit, got.hit, want.found_frame, got.found_frame,
						want.evicted, got.evicted, want.evicted_page, got.evicted_page);
			end
		end
		n_checked++;
	endtask

	// sample the response side and the watchdog mid-cycle
	always @(negedge clk) begin
		rsp_go = rsp_valid && !rsp_stall;
		rsp_snap = rsp;
		if ((req_valid && !req_stall) || rsp_go)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("watchdog: no handshake for %0d cycles, %0d words outstanding",
				WATCHDOG, expected_rsp.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rsp_go)
			check_word(rsp_snap);
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		tlb_pkg::req_word_t w;
		tlb_pkg::func_t     fn;
		int                 pick;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tlb_pkg::CFG_REPLACE_MODE;
		cfg_data = '0;

		// empty buffer, extremes, duplicates, unused code, flush
		row_known(tlb_pkg::FUNC_LOOKUP, 20'h00000, 20'h00000, '0);
		row_known(tlb_pkg::FUNC_LOOKUP, 20'hFFFFF, 20'hFFFFF, '0);
		row_known(tlb_pkg::FUNC_INSERT, 20'hFFFFF, 20'hFFFFF, '0);
		row_known(tlb_pkg::FUNC_INSERT, 20'h00000, 20'h00000, '0);
		row_known(tlb_pkg::FUNC_LOOKUP, 20'hFFFFF, 20'h00000,
			{1'b1, 20'hFFFFF, 1'b0, 20'h0});
		row_known(tlb_pkg::FUNC_LOOKUP, 20'h00000, 20'hFFFFF,
			{1'b1, 20'h00000, 1'b0, 20'h0});
		row_known(tlb_pkg::FUNC_INSERT, 20'hFFFFF, 20'h12345, '0);
		row_word(tlb_pkg::FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
		row_known(tlb_pkg::FUNC_NONE, 20'hFFFFF, 20'hFFFFF, '0);
		row_known(tlb_pkg::FUNC_FLUSH, 20'hFFFFF, 20'hFFFFF, '0);
		row_known(tlb_pkg::FUNC_LOOKUP, 20'hFFFFF, 20'h00000, '0);
		// single entry, then capacity of zero
		row_regs(1'b1, 5'd1);
		row_known(tlb_pkg::FUNC_INSERT, 20'hA5A5A, 20'h5A5A5, '0);
		row_known(tlb_pkg::FUNC_INSERT, 20'h5A5A5, 20'hA5A5A,
			{1'b0, 20'h0, 1'b1, 20'hA5A5A});
		row_word(tlb_pkg::FUNC_LOOKUP, 20'h5A5A5, 20'h00000);
		row_regs(1'b1, 5'd0);
		row_word(tlb_pkg::FUNC_INSERT, 20'h12345, 20'h54321);
		// lru reorder, then capacity dropped below the fill
		row_regs(1'b1, 5'd3);
		row_known(tlb_pkg::FUNC_FLUSH, 20'h00000, 20'h00000, '0);
		row_word(tlb_pkg::FUNC_INSERT, 20'h00011, 20'h000AA);
		row_word(tlb_pkg::FUNC_INSERT, 20'h00022, 20'h000BB);
		row_word(tlb_pkg::FUNC_INSERT, 20'h00033, 20'h000CC);
		row_word(tlb_pkg::FUNC_LOOKUP, 20'h00011, 20'h00000);
		row_word(tlb_pkg::FUNC_INSERT, 20'h00044, 20'h000DD);
		row_regs(1'b0, 5'd1);
		row_word(tlb_pkg::FUNC_INSERT, 20'h00055, 20'h000EE);
		row_word(tlb_pkg::FUNC_LOOKUP, 20'h00033, 20'h00000);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				set_regs(script[i].mode, script[i].cap);
			end else begin
				send_word(script[i].w, script[i].known, script[i].r);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph < 2) begin
				send_idle_pct = 38;
				recv_idle_pct = 46;
			end else if (ph < 4) begin
				send_idle_pct = 46;
				recv_idle_pct = 38;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_regs(phase_mode[ph], phase_cap[ph]);
			foreach (hot_pages[i])
				hot_pages[i] = tlb_pkg::page_t'($urandom);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// let the pipe run dry once, midway through phase 1
				if (ph == 1 && n == PHASE_WORDS / 2)
					settle();
				pick = $urandom_range(99);
				if (pick < 50)
					fn = tlb_pkg::FUNC_LOOKUP;
				else if (pick < 92)
					fn = tlb_pkg::FUNC_INSERT;
				else if (pick < 96)
					fn = tlb_pkg::FUNC_NONE;
				else
					fn = tlb_pkg::FUNC_FLUSH;
				w.func = fn;
				w.page_number = ($urandom_range(99) < 85) ? hot_pages[$urandom_range(HOT - 1)]
					: tlb_pkg::page_t'($urandom);
				w.frame_number = tlb_pkg::frame_t'($urandom);
				send_word(w, 1'b0, '0);
			end
		end

		settle();
		bad += expected_rsp.size();
		$display("%0d words: %0d lookups with %0d hits, %0d inserts with %0d evictions",
			n_words, n_lookups, n_hits, n_inserts, n_evictions);
		$display("%0d flushes, %0d responses checked over %0d register settings",
			n_flushes, n_checked, PHASES + 4);
		if (bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
src/tlb_pkg.sv
src/tlb_cell.sv
src/tlb_fifo_lru_lookup.sv
src/tlb_checker.sv
tb/tb.sv
